// ----- rtl/kar_pkg.sv -----
package kar_pkg;

  localparam int unsigned KEY_W  = 10;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned MODS_W = 4;
  localparam int unsigned FLAG_W = 3;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned NCODES = 4;

  typedef enum logic [1:0] {
    REQ_KEY        = 2'd0,
    REQ_MODS       = 2'd1,
    REQ_FOCUS_LOST = 2'd2,
    REQ_TICK       = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_HOLD   = 3'd0,
    REG_REPEAT = 3'd1,
    REG_CODE_A = 3'd2,
    REG_CODE_B = 3'd3,
    REG_CODE_C = 3'd4,
    REG_CODE_D = 3'd5
  } reg_idx_t;

  localparam logic [TICK_W-1:0] HOLD_RST   = 16'd500;
  localparam logic [TICK_W-1:0] REPEAT_RST = 16'd50;
  localparam logic [KEY_W-1:0]  CODE_A_RST = 10'd105;
  localparam logic [KEY_W-1:0]  CODE_B_RST = 10'd106;
  localparam logic [KEY_W-1:0]  CODE_C_RST = 10'd103;
  localparam logic [KEY_W-1:0]  CODE_D_RST = 10'd108;

  typedef struct packed {
    req_t              req_type;
    logic [KEY_W-1:0]  key_code;
    logic              key_press;
    logic [MODS_W-1:0] mods_held;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic              pressed;
    logic [FLAG_W-1:0] modifiers;
    logic              auto_rep;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0]             hold_ticks;
    logic [TICK_W-1:0]             repeat_ticks;
    logic [NCODES-1:0][KEY_W-1:0]  codes;
  } cfg_t;

endpackage

// ----- rtl/kar_if.sv -----
interface kar_in_if;
  import kar_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [KEY_W-1:0]  key_code;
  logic              key_press;
  logic [MODS_W-1:0] mods_held;

  modport source (output valid, req_type, key_code, key_press, mods_held, input ready);
  modport sink   (input valid, req_type, key_code, key_press, mods_held, output ready);
endinterface

interface kar_out_if;
  import kar_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  out_key_code;
  logic              out_pressed;
  logic [FLAG_W-1:0] out_modifiers;
  logic              out_auto;

  modport source (output valid, out_key_code, out_pressed, out_modifiers, out_auto,
                  input ready);
  modport sink   (input valid, out_key_code, out_pressed, out_modifiers, out_auto,
                  output ready);
endinterface

// ----- rtl/kar_cfg_regs.sv -----
module kar_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kar_pkg::ADDR_W-1:0] paddr,
  input  logic [kar_pkg::DATA_W-1:0] pwdata,
  output logic [kar_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output kar_pkg::cfg_t              cfg
);
  import kar_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks   <= HOLD_RST;
      cfg_r.repeat_ticks <= REPEAT_RST;
      cfg_r.codes[0]     <= CODE_A_RST;
      cfg_r.codes[1]     <= CODE_B_RST;
      cfg_r.codes[2]     <= CODE_C_RST;
      cfg_r.codes[3]     <= CODE_D_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HOLD:   cfg_r.hold_ticks   <= pwdata[TICK_W-1:0];
        REG_REPEAT: cfg_r.repeat_ticks <= pwdata[TICK_W-1:0];
        REG_CODE_A: cfg_r.codes[0]     <= pwdata[KEY_W-1:0];
        REG_CODE_B: cfg_r.codes[1]     <= pwdata[KEY_W-1:0];
        REG_CODE_C: cfg_r.codes[2]     <= pwdata[KEY_W-1:0];
        REG_CODE_D: cfg_r.codes[3]     <= pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_HOLD:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.hold_ticks};
      REG_REPEAT: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.repeat_ticks};
      REG_CODE_A: prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_r.codes[0]};
      REG_CODE_B: prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_r.codes[1]};
      REG_CODE_C: prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_r.codes[2]};
      REG_CODE_D: prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_r.codes[3]};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/kar_core.sv -----
module kar_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  kar_pkg::item_t  item,
  input  kar_pkg::cfg_t   cfg,
  output logic            emit,
  output kar_pkg::result_t res
);
  import kar_pkg::*;

  logic              armed_r, armed_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              phase_r, phase_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic              rep;

  assign rep = (item.key_code == cfg.codes[0]) || (item.key_code == cfg.codes[1]) ||
               (item.key_code == cfg.codes[2]) || (item.key_code == cfg.codes[3]);

  always_comb begin
    armed_nxt = armed_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    flags_nxt = flags_r;
    emit      = 1'b0;
    res       = '{key_code: item.key_code, pressed: item.key_press,
                  modifiers: flags_r, auto_rep: 1'b0};
    case (item.req_type)
      REQ_KEY: begin
        if (!(item.key_press && rep && item.key_code == key_r && armed_r)) begin
          emit = 1'b1;
          if (rep && item.key_press) begin
            armed_nxt = 1'b1;
            key_nxt   = item.key_code;
            count_nxt = phase_r ? cfg.repeat_ticks : cfg.hold_ticks;
          end else begin
            armed_nxt = 1'b0;
            phase_nxt = 1'b0;
            count_nxt = '0;
          end
        end
      end
      REQ_MODS: begin
        flags_nxt = {item.mods_held[3], item.mods_held[2], item.mods_held[0]};
      end
      REQ_FOCUS_LOST: begin
        armed_nxt = 1'b0;
        count_nxt = '0;
      end
      REQ_TICK: begin
        if (armed_r) begin
          if (count_r > TICK_W'(1)) begin
            count_nxt = count_r - TICK_W'(1);
          end else begin
            emit      = 1'b1;
            res       = '{key_code: key_r, pressed: 1'b1,
                          modifiers: flags_r, auto_rep: 1'b1};
            phase_nxt = 1'b1;
            count_nxt = cfg.repeat_ticks;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      key_r   <= '0;
      phase_r <= 1'b0;
      count_r <= '0;
      flags_r <= '0;
    end else if (step) begin
      armed_r <= armed_nxt;
      key_r   <= key_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

// ----- rtl/key_auto_repeat_controller_top.sv -----
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        req_type, key_code, key_press, mods_held
// out_ch   out  valid/ready        out_key_code, out_pressed, out_modifiers, out_auto
// cfg      in   psel/penable (APB) paddr, pwdata, prdata
//
// One item per cycle unless a held result stalls the input; an accepted item
// passes through the input register and the state update, then the result register.
// rst_n is synchronous: clears the pipeline valids, repeat state and configuration registers.
// A held result stalls the input only when the next item also gives a result.
module key_auto_repeat_controller_top (
  input  logic                       clk,
  input  logic                       rst_n,
  kar_in_if.sink                     in_ch,
  kar_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kar_pkg::ADDR_W-1:0] paddr,
  input  logic [kar_pkg::DATA_W-1:0] pwdata,
  output logic [kar_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import kar_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  logic    emit;
  result_t res;
  logic    out_free;
  logic    advance;
  logic    in_ready;

  kar_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kar_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .emit  (emit),
    .res   (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && (!emit || out_free);
  assign in_ready    = !in_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_item_r <= '{req_type: req_t'(in_ch.req_type), key_code: in_ch.key_code,
                     key_press: in_ch.key_press, mods_held: in_ch.mods_held};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid_r && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_key_code  = out_res_r.key_code;
  assign out_ch.out_pressed   = out_res_r.pressed;
  assign out_ch.out_modifiers = out_res_r.modifiers;
  assign out_ch.out_auto      = out_res_r.auto_rep;

endmodule

// ----- rtl/kar_checker.sv -----
module kar_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [kar_pkg::KEY_W-1:0]  out_key_code,
  input logic                       out_pressed,
  input logic                       out_auto,
  input logic                       pready
);
  import kar_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_key_code))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_auto_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_auto |-> out_pressed && pready)
    else $error("auto-repeat transfer not a press");

endmodule

bind key_auto_repeat_controller_top kar_checker u_kar_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_key_code (out_ch.out_key_code),
  .out_pressed  (out_ch.out_pressed),
  .out_auto     (out_ch.out_auto),
  .pready       (pready)
);
